[src/assert_macros.svh]
// assertion macros for the checker file mexs_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MEXS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// delayed implication, disabled while reset is asserted
`define MEXS_ASSERT_DELAY2(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

[src/mexs_pkg.sv]
// opcode and function codes plus the stage-one request type
// for the mips execute stage; no dependencies
`timescale 1ns / 1ps

package mexs_pkg;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	// function codes under the special opcode
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	// link register for jal
	localparam logic [4:0] REG_LINK = 5'd31;

	// configuration register indexes
	localparam logic REG_IDX_PREDICT = 1'b0;

	// captured request
	typedef struct packed {
		logic [5:0]  opcode;
		logic [5:0]  funct;
		logic [4:0]  rt_index;
		logic [4:0]  rd_index;
		logic [4:0]  shift_amount;
		logic [15:0] immediate;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
		logic [31:0] inst_pc;
	} req_t;

endpackage

[src/mips_execute_stage_unit.sv]
// mips execute stage: start to done passes the input register, then the result register
// throughput one request per cycle; busy is always low, results are never held off
// the decode, alu, address and branch logic sit in one stage between the two registers
// arst_n clears the valid bits and predict_taken; payload registers are not reset
// depends on mexs_pkg
`timescale 1ns / 1ps

module mips_execute_stage_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  opcode,
	input  logic [5:0]  funct,
	input  logic [4:0]  rt_index,
	input  logic [4:0]  rd_index,
	input  logic [4:0]  shift_amount,
	input  logic [15:0] immediate,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] inst_pc,
	// result
	output logic        done,
	output logic        write_enable,
	output logic [4:0]  write_reg,
	output logic [31:0] write_value,
	output logic        mem_load,
	output logic        mem_write,
	output logic [31:0] mem_address,
	output logic [31:0] store_value,
	output logic        redirect,
	output logic [31:0] redirect_pc,
	output logic        squash_younger
);
	import mexs_pkg::*;

	logic        predict_taken_q;
	logic        cfg_wr;
	logic        req_valid_s1;
	req_t        req_s1;
	logic [31:0] imm_sext;
	logic [31:0] imm_zext;
	logic [31:0] pc_plus4;
	logic [31:0] sum_addr;
	logic        ops_equal;
	logic        taken;
	logic        nx_we;
	logic [4:0]  nx_wreg;
	logic [31:0] nx_wval;
	logic        nx_mrd;
	logic        nx_mwr;
	logic [31:0] nx_addr;
	logic [31:0] nx_sval;
	logic        nx_redir;
	logic [31:0] nx_rpc;
	logic        nx_squash;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predict_taken_q <= 1'b0;
		end else if (cfg_wr && (paddr[2] == REG_IDX_PREDICT)) begin
			predict_taken_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDX_PREDICT) begin
			prdata = {31'd0, predict_taken_q};
		end
	end

	// input register
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= {opcode, funct, rt_index, rd_index, shift_amount,
				immediate, rs_value, rt_value, inst_pc};
		end
	end

	// shared operand forms
	assign imm_sext  = {{16{req_s1.immediate[15]}}, req_s1.immediate};
	assign imm_zext  = {16'd0, req_s1.immediate};
	assign pc_plus4  = req_s1.inst_pc + 32'd4;
	assign sum_addr  = req_s1.rs_value + imm_sext;
	assign ops_equal = (req_s1.rs_value == req_s1.rt_value);
	assign taken     = (req_s1.opcode == OP_BEQ) ? ops_equal : !ops_equal;

	// decode and execute
	always_comb begin
		nx_we     = 1'b0;
		nx_wreg   = '0;
		nx_wval   = '0;
		nx_mrd    = 1'b0;
		nx_mwr    = 1'b0;
		nx_addr   = '0;
		nx_sval   = '0;
		nx_redir  = 1'b0;
		nx_rpc    = '0;
		nx_squash = 1'b0;
		case (req_s1.opcode)
			OP_SPECIAL: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rd_index;
				case (req_s1.funct)
					FN_ADDU: nx_wval = req_s1.rs_value + req_s1.rt_value;
					FN_SUBU: nx_wval = req_s1.rs_value - req_s1.rt_value;
					FN_AND:  nx_wval = req_s1.rs_value & req_s1.rt_value;
					FN_OR:   nx_wval = req_s1.rs_value | req_s1.rt_value;
					FN_NOR:  nx_wval = ~(req_s1.rs_value | req_s1.rt_value);
					FN_SLL:  nx_wval = req_s1.rt_value << req_s1.shift_amount;
					FN_SRL:  nx_wval = req_s1.rt_value >> req_s1.shift_amount;
					FN_SLTU: nx_wval = {31'd0, req_s1.rs_value < req_s1.rt_value};
					default: begin
						// jr and unknown functions write nothing
						nx_we   = 1'b0;
						nx_wreg = '0;
					end
				endcase
			end
			OP_JAL: begin
				nx_we   = 1'b1;
				nx_wreg = REG_LINK;
				nx_wval = pc_plus4;
			end
			OP_ADDIU: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rt_index;
				nx_wval = sum_addr;
			end
			OP_ANDI: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rt_index;
				nx_wval = req_s1.rs_value & imm_zext;
			end
			OP_ORI: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rt_index;
				nx_wval = req_s1.rs_value | imm_zext;
			end
			OP_SLTIU: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rt_index;
				nx_wval = {31'd0, req_s1.rs_value < imm_sext};
			end
			OP_LUI: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rt_index;
				nx_wval = {req_s1.immediate, 16'd0};
			end
			OP_LW: begin
				nx_we   = 1'b1;
				nx_wreg = req_s1.rt_index;
				nx_mrd  = 1'b1;
				nx_addr = sum_addr;
			end
			OP_SW: begin
				nx_mwr  = 1'b1;
				nx_addr = sum_addr;
				nx_sval = req_s1.rt_value;
			end
			OP_BEQ, OP_BNE: begin
				if (!predict_taken_q) begin
					// no predictor: always steer fetch to the resolved pc
					nx_redir = 1'b1;
					nx_rpc   = taken ? (pc_plus4 + {imm_sext[29:0], 2'b00}) : pc_plus4;
				end else if (!taken) begin
					// predicted taken but falls through
					nx_redir  = 1'b1;
					nx_rpc    = pc_plus4;
					nx_squash = 1'b1;
				end
			end
			default: begin
				// unknown opcodes have no effect
				nx_we = 1'b0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid_s1) begin
			write_enable   <= nx_we;
			write_reg      <= nx_wreg;
			write_value    <= nx_wval;
			mem_load       <= nx_mrd;
			mem_write      <= nx_mwr;
			mem_address    <= nx_addr;
			store_value    <= nx_sval;
			redirect       <= nx_redir;
			redirect_pc    <= nx_rpc;
			squash_younger <= nx_squash;
		end
	end

endmodule

[src/mexs_checker.sv]
// port-level checks for the mips execute stage, bound into mips_execute_stage_unit
// depends on assert_macros.svh and mips_execute_stage_unit
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mexs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        write_enable,
	input logic        mem_load,
	input logic        mem_write,
	input logic        redirect,
	input logic [31:0] redirect_pc,
	input logic        squash_younger
);

	// every accepted request yields a result on done
	`MEXS_ASSERT_DELAY2(a_req_to_done, clk, arst_n, start && !busy, done, "missing result")

	// a store never writes a register and never loads
	`MEXS_ASSERT_IMPLY(a_store_only, clk, arst_n, done && mem_write, !write_enable && !mem_load, "store with write-back or load")

	// squash only comes with a redirect
	`MEXS_ASSERT_IMPLY(a_squash_redir, clk, arst_n, done && squash_younger, redirect, "squash without redirect")

	// no redirect means a clear target and no squash
	`MEXS_ASSERT_IMPLY(a_idle_target, clk, arst_n, done && !redirect, redirect_pc == 32'd0 && !squash_younger, "stale redirect target")

endmodule

bind mips_execute_stage_unit mexs_checker u_mexs_checker (.*);

[tb/sv/tb.sv]
// self-checking testbench for the mips execute stage unit
// drives requests and apb writes, predicts each result and compares; uses mexs_pkg
`timescale 1ns / 1ps

module tb;
	import mexs_pkg::*;

	// codes that the stage must ignore
	localparam logic [5:0] OP_J   = 6'd2;
	localparam logic [5:0] OP_UNK = 6'd63;
	localparam logic [5:0] FN_JR  = 6'h08;
	localparam logic [5:0] FN_UNK = 6'h3F;

	localparam logic [2:0] ADDR_PREDICT = {REG_IDX_PREDICT, 2'b00};
	localparam int CYCLE_LIMIT = 100000;
	localparam int RESULT_LATENCY = 2;

	// one execute result, field order as on the ports
	typedef struct packed {
		logic        we;
		logic [4:0]  wreg;
		logic [31:0] wval;
		logic        mrd;
		logic        mwr;
		logic [31:0] addr;
		logic [31:0] sval;
		logic        redir;
		logic [31:0] rpc;
		logic        squash;
	} exec_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [5:0]  opcode;
	logic [5:0]  funct;
	logic [4:0]  rt_index;
	logic [4:0]  rd_index;
	logic [4:0]  shift_amount;
	logic [15:0] immediate;
	logic [31:0] rs_value;
	logic [31:0] rt_value;
	logic [31:0] inst_pc;
	logic        done;
	logic        write_enable;
	logic [4:0]  write_reg;
	logic [31:0] write_value;
	logic        mem_load;
	logic        mem_write;
	logic [31:0] mem_address;
	logic [31:0] store_value;
	logic        redirect;
	logic [31:0] redirect_pc;
	logic        squash_younger;

	exec_result_t pending_results[$];
	logic         predict_cfg;
	int           mismatch_count;
	int           cycle_count;

	mips_execute_stage_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.opcode(opcode), .funct(funct), .rt_index(rt_index), .rd_index(rd_index),
		.shift_amount(shift_amount), .immediate(immediate),
		.rs_value(rs_value), .rt_value(rt_value), .inst_pc(inst_pc),
		.done(done), .write_enable(write_enable), .write_reg(write_reg),
		.write_value(write_value), .mem_load(mem_load), .mem_write(mem_write),
		.mem_address(mem_address), .store_value(store_value),
		.redirect(redirect), .redirect_pc(redirect_pc),
		.squash_younger(squash_younger)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// computes the result the stage must give for one instruction
	function automatic exec_result_t execute_instr(req_t r, logic pt);
		exec_result_t x;
		logic [31:0]  imms;
		logic [31:0]  immz;
		logic [31:0]  pc4;
		logic         taken;
		x = '0;
		imms = {{16{r.immediate[15]}}, r.immediate};
		immz = {16'h0000, r.immediate};
		pc4 = r.inst_pc + 32'd4;
		case (r.opcode)
			OP_SPECIAL: begin
				x.we = 1'b1;
				case (r.funct)
					FN_ADDU: x.wval = r.rs_value + r.rt_value;
					FN_SUBU: x.wval = r.rs_value - r.rt_value;
					FN_AND:  x.wval = r.rs_value & r.rt_value;
					FN_OR:   x.wval = r.rs_value | r.rt_value;
					FN_NOR:  x.wval = ~(r.rs_value | r.rt_value);
					FN_SLL:  x.wval = r.rt_value << r.shift_amount;
					FN_SRL:  x.wval = r.rt_value >> r.shift_amount;
					FN_SLTU: x.wval = {31'd0, r.rs_value < r.rt_value};
					default: x.we = 1'b0;
				endcase
				if (x.we)
					x.wreg = r.rd_index;
			end
			OP_JAL: begin
				x.we = 1'b1;
				x.wreg = REG_LINK;
				x.wval = pc4;
			end
			OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTIU, OP_LUI, OP_LW: begin
				x.we = 1'b1;
				x.wreg = r.rt_index;
				case (r.opcode)
					OP_ADDIU: x.wval = r.rs_value + imms;
					OP_ANDI:  x.wval = r.rs_value & immz;
					OP_ORI:   x.wval = r.rs_value | immz;
					OP_SLTIU: x.wval = {31'd0, r.rs_value < imms};
					OP_LUI:   x.wval = {r.immediate, 16'h0000};
					default: begin
						x.mrd = 1'b1;
						x.addr = r.rs_value + imms;
					end
				endcase
			end
			OP_SW: begin
				x.mwr = 1'b1;
				x.addr = r.rs_value + imms;
				x.sval = r.rt_value;
			end
			OP_BEQ, OP_BNE: begin
				taken = (r.opcode == OP_BEQ) ? (r.rs_value == r.rt_value)
					: (r.rs_value != r.rt_value);
				if (!pt) begin
					x.redir = 1'b1;
					x.rpc = taken ? pc4 + (imms << 2) : pc4;
				end else if (!taken) begin
					x.redir = 1'b1;
					x.rpc = pc4;
					x.squash = 1'b1;
				end
			end
			default: ;
		endcase
		return x;
	endfunction

	function automatic req_t make_instr(logic [5:0] op, logic [5:0] fn, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sa, logic [15:0] imm, logic [31:0] rsv,
			logic [31:0] rtv, logic [31:0] pc);
		req_t r;
		r.opcode = op;
		r.funct = fn;
		r.rt_index = rt;
		r.rd_index = rd;
		r.shift_amount = sa;
		r.immediate = imm;
		r.rs_value = rsv;
		r.rt_value = rtv;
		r.inst_pc = pc;
		return r;
	endfunction

	// operand values with a bias toward the corners
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// mostly supported instructions with random content, some noise
	function automatic req_t random_instr();
		req_t r;
		int   pick;
		r.funct = 6'($urandom);
		r.rt_index = 5'($urandom);
		r.rd_index = 5'($urandom);
		r.shift_amount = 5'($urandom);
		case ($urandom_range(0, 5))
			0: r.immediate = 16'h0000;
			1: r.immediate = 16'hFFFF;
			2: r.immediate = 16'h8000;
			3: r.immediate = 16'h7FFF;
			default: r.immediate = 16'($urandom);
		endcase
		r.rs_value = rand_word();
		r.rt_value = rand_word();
		r.inst_pc = rand_word();
		pick = $urandom_range(0, 19);
		case (pick)
			0, 1, 2, 3, 4, 5: begin
				r.opcode = OP_SPECIAL;
				case ($urandom_range(0, 7))
					0: r.funct = FN_ADDU;
					1: r.funct = FN_SUBU;
					2: r.funct = FN_AND;
					3: r.funct = FN_OR;
					4: r.funct = FN_NOR;
					5: r.funct = FN_SLL;
					6: r.funct = FN_SRL;
					default: r.funct = FN_SLTU;
				endcase
			end
			6: r.opcode = OP_JAL;
			7: r.opcode = OP_ADDIU;
			8: r.opcode = OP_ANDI;
			9: r.opcode = OP_ORI;
			10: r.opcode = OP_SLTIU;
			11: r.opcode = OP_LUI;
			12: r.opcode = OP_LW;
			13: r.opcode = OP_SW;
			14, 15: r.opcode = OP_BEQ;
			16, 17: r.opcode = OP_BNE;
			18: r.opcode = OP_SPECIAL;
			default: r.opcode = 6'($urandom);
		endcase
		// equal operands so that both branch outcomes are frequent
		if ((r.opcode == OP_BEQ || r.opcode == OP_BNE) && $urandom_range(0, 1))
			r.rt_value = r.rs_value;
		return r;
	endfunction

	// presents one request and waits for it to be taken
	task automatic send_instr(req_t r);
		opcode <= r.opcode;
		funct <= r.funct;
		rt_index <= r.rt_index;
		rd_index <= r.rd_index;
		shift_amount <= r.shift_amount;
		immediate <= r.immediate;
		rs_value <= r.rs_value;
		rt_value <= r.rt_value;
		inst_pc <= r.inst_pc;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(execute_instr(r, predict_cfg));
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// holds the sender off until every result has arrived
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	// apb write of predict_taken with a read back
	task automatic write_predict(logic v);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PREDICT;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		predict_cfg = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[0] !== v) begin
			$error("predict_taken readback: expected %0h, got %0h", v, prdata[0]);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_register_ops();
		send_instr(make_instr(OP_SPECIAL, FN_ADDU, 5'd0, 5'd31, 5'd0, 16'h0,
			32'hFFFF_FFFF, 32'h0000_0001, 32'h0));
		send_instr(make_instr(OP_SPECIAL, FN_SUBU, 5'd31, 5'd1, 5'd31, 16'hFFFF,
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
		send_instr(make_instr(OP_SPECIAL, FN_AND, 5'd3, 5'd2, 5'd0, 16'h0,
			32'hF0F0_F0F0, 32'hFF00_FF00, 32'h100));
		send_instr(make_instr(OP_SPECIAL, FN_OR, 5'd3, 5'd4, 5'd0, 16'h0,
			32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'h104));
		send_instr(make_instr(OP_SPECIAL, FN_NOR, 5'd3, 5'd5, 5'd0, 16'h0,
			32'h0000_0000, 32'h0000_0000, 32'h108));
		// sll with rt 0 is a real shift, not a nop
		send_instr(make_instr(OP_SPECIAL, FN_SLL, 5'd0, 5'd6, 5'd31, 16'h0,
			32'h0, 32'h0000_0003, 32'h10C));
		send_instr(make_instr(OP_SPECIAL, FN_SRL, 5'd7, 5'd7, 5'd31, 16'h0,
			32'h0, 32'h8000_0000, 32'h110));
		send_instr(make_instr(OP_SPECIAL, FN_SLTU, 5'd8, 5'd8, 5'd0, 16'h0,
			32'h0000_0001, 32'hFFFF_FFFF, 32'h114));
		// link address wraps at the top of memory
		send_instr(make_instr(OP_JAL, 6'h0, 5'd0, 5'd0, 5'd0, 16'h0,
			32'h0, 32'h0, 32'hFFFF_FFFC));
	endtask

	task automatic test_immediate_ops();
		send_instr(make_instr(OP_ADDIU, 6'h0, 5'd9, 5'd0, 5'd0, 16'hFFFF,
			32'h0000_0000, 32'h0, 32'h200));
		// andi and ori zero-extend, sltiu sign-extends then compares unsigned
		send_instr(make_instr(OP_ANDI, 6'h0, 5'd10, 5'd0, 5'd0, 16'hFFFF,
			32'hFFFF_FFFF, 32'h0, 32'h204));
		send_instr(make_instr(OP_ORI, 6'h0, 5'd11, 5'd0, 5'd0, 16'h8000,
			32'h0000_0000, 32'h0, 32'h208));
		send_instr(make_instr(OP_SLTIU, 6'h0, 5'd12, 5'd0, 5'd0, 16'hFFFF,
			32'hFFFF_FFFE, 32'h0, 32'h20C));
		send_instr(make_instr(OP_LUI, 6'h0, 5'd31, 5'd0, 5'd0, 16'hFFFF,
			32'h1234_5678, 32'h0, 32'h210));
	endtask

	task automatic test_memory_ops();
		send_instr(make_instr(OP_LW, 6'h0, 5'd13, 5'd0, 5'd0, 16'h8000,
			32'h0000_0004, 32'hDEAD_BEEF, 32'h300));
		send_instr(make_instr(OP_SW, 6'h0, 5'd14, 5'd0, 5'd0, 16'h7FFF,
			32'hFFFF_FFFF, 32'hCAFE_F00D, 32'h304));
	endtask

	// jr, j, unknown funct and unknown opcode give an empty result
	task automatic test_ignored_ops();
		send_instr(make_instr(OP_SPECIAL, FN_JR, 5'd1, 5'd2, 5'd3, 16'h0,
			32'h1234_5678, 32'h1, 32'h400));
		send_instr(make_instr(OP_J, 6'h0, 5'd1, 5'd2, 5'd3, 16'hFFFF,
			32'h1, 32'h1, 32'h404));
		send_instr(make_instr(OP_SPECIAL, FN_UNK, 5'd1, 5'd2, 5'd3, 16'h0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h408));
		send_instr(make_instr(OP_UNK, FN_UNK, 5'd31, 5'd31, 5'd31, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
	endtask

	// taken and not-taken branches under the current predictor setting
	task automatic test_branches();
		// backward target wraps below zero
		send_instr(make_instr(OP_BEQ, 6'h0, 5'd0, 5'd0, 5'd0, 16'h8000,
			32'h5555_5555, 32'h5555_5555, 32'h0000_0000));
		send_instr(make_instr(OP_BEQ, 6'h0, 5'd0, 5'd0, 5'd0, 16'h7FFF,
			32'h5555_5555, 32'h5555_5554, 32'hFFFF_FFF8));
		send_instr(make_instr(OP_BNE, 6'h0, 5'd0, 5'd0, 5'd0, 16'h7FFF,
			32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
		send_instr(make_instr(OP_BNE, 6'h0, 5'd0, 5'd0, 5'd0, 16'hFFFF,
			32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h8000_0000));
	endtask

	// random instruction mix with optional bursts of idle cycles
	task automatic test_random_mix(int count, bit allow_idle);
		int idle_rate;
		idle_rate = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				idle_rate = $urandom_range(0, 2);
			if (i == count / 2)
				drain_results();
			send_instr(random_instr());
			if (allow_idle && idle_rate != 0 && $urandom_range(0, 3) < idle_rate)
				idle_cycles($urandom_range(1, 5));
		end
	endtask

	// field compare against the oldest expectation
	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("write_enable", 32'(want.we), 32'(write_enable));
				check_field("write_reg", 32'(want.wreg), 32'(write_reg));
				check_field("write_value", want.wval, write_value);
				check_field("mem_load", 32'(want.mrd), 32'(mem_load));
				check_field("mem_write", 32'(want.mwr), 32'(mem_write));
				check_field("mem_address", want.addr, mem_address);
				check_field("store_value", want.sval, store_value);
				check_field("redirect", 32'(want.redir), 32'(redirect));
				check_field("redirect_pc", want.rpc, redirect_pc);
				check_field("squash_younger", 32'(want.squash), 32'(squash_younger));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// test sequence
	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		predict_cfg = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		opcode <= '0;
		funct <= '0;
		rt_index <= '0;
		rd_index <= '0;
		shift_amount <= '0;
		immediate <= '0;
		rs_value <= '0;
		rt_value <= '0;
		inst_pc <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: no predictor
		test_register_ops();
		test_immediate_ops();
		test_memory_ops();
		test_ignored_ops();
		test_branches();
		write_predict(1'b1);
		test_branches();
		write_predict(1'b0);

		test_random_mix(300, 1'b1);
		write_predict(1'b1);
		test_random_mix(300, 1'b1);
		write_predict(1'b0);
		test_random_mix(200, 1'b0);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 6) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/mexs_pkg.sv
src/mips_execute_stage_unit.sv
src/mexs_checker.sv
tb/sv/tb.sv
